// ===== rtl/pth_pkg.sv =====
// Shared types, widths and the arctangent table for the path heading block.
package pth_pkg;

  localparam int COORD_W  = 32;
  localparam int ANGLE_W  = 16;
  localparam int INDEX_W  = 16;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int ROT_W    = DIFF_W + 3;
  localparam int PHASE_W  = 32;
  localparam int ATAN_MAX = 24;

  localparam logic [INDEX_W-1:0] INDEX_MAX     = {INDEX_W{1'b1}};
  localparam logic [PHASE_W-1:0] PHASE_QUARTER = 32'h4000_0000;
  localparam logic [PHASE_W-1:0] PHASE_3QUART  = 32'hC000_0000;
  localparam logic [PHASE_W-1:0] PHASE_HALF_LSB =
    PHASE_W'(1) << (PHASE_W - ANGLE_W - 1);

  typedef struct packed {
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic                      end_of_path;
  } in_item_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] heading;
    logic [INDEX_W-1:0]        point_index;
    logic                      last_heading;
  } out_item_t;

  // One heading request: a difference vector plus its tags.
  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic [INDEX_W-1:0]       point_index;
    logic                     last_heading;
  } req_t;

  // atan(2^-i), 2^32 units per turn
  function automatic logic [PHASE_W-1:0] atan_entry(input logic [4:0] i);
    logic [PHASE_W-1:0] v;
    case (i)
      5'd0:  v = 32'h2000_0000;
      5'd1:  v = 32'h12E4_051E;
      5'd2:  v = 32'h09FB_385B;
      5'd3:  v = 32'h0511_11D4;
      5'd4:  v = 32'h028B_0D43;
      5'd5:  v = 32'h0145_D7E1;
      5'd6:  v = 32'h00A2_F61E;
      5'd7:  v = 32'h0051_7C55;
      5'd8:  v = 32'h0028_BE53;
      5'd9:  v = 32'h0014_5F2F;
      5'd10: v = 32'h000A_2F98;
      5'd11: v = 32'h0005_17CC;
      5'd12: v = 32'h0002_8BE6;
      5'd13: v = 32'h0001_45F3;
      5'd14: v = 32'h0000_A2FA;
      5'd15: v = 32'h0000_517D;
      5'd16: v = 32'h0000_28BE;
      5'd17: v = 32'h0000_145F;
      5'd18: v = 32'h0000_0A30;
      5'd19: v = 32'h0000_0518;
      5'd20: v = 32'h0000_028C;
      5'd21: v = 32'h0000_0146;
      5'd22: v = 32'h0000_00A3;
      5'd23: v = 32'h0000_0051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/pth_front.sv =====
// Front end: point window, index count and difference requests.
module pth_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  pth_pkg::in_item_t in_data,
  output logic             push_valid,
  input  logic             push_ready,
  output pth_pkg::req_t    push_req
);

  logic signed [pth_pkg::COORD_W-1:0] px_r [0:1];
  logic signed [pth_pkg::COORD_W-1:0] py_r [0:1];
  logic [pth_pkg::INDEX_W-1:0]        seen_r;
  logic                               pend_valid_r;
  pth_pkg::req_t                      pend_req_r;

  logic                              accept;
  logic                              has_prev;
  logic                              near;
  logic signed [pth_pkg::DIFF_W-1:0] cx, cy, p0x, p0y, p1x, p1y;
  pth_pkg::req_t                     req_a, req_b;

  assign in_ready = !pend_valid_r && push_ready;
  assign accept   = in_valid && in_ready;
  assign has_prev = (seen_r != '0);
  assign near     = (seen_r == pth_pkg::INDEX_W'(1));

  assign cx  = $signed({in_data.x_coord[pth_pkg::COORD_W-1], in_data.x_coord});
  assign cy  = $signed({in_data.y_coord[pth_pkg::COORD_W-1], in_data.y_coord});
  assign p0x = $signed({px_r[0][pth_pkg::COORD_W-1], px_r[0]});
  assign p0y = $signed({py_r[0][pth_pkg::COORD_W-1], py_r[0]});
  assign p1x = $signed({px_r[1][pth_pkg::COORD_W-1], px_r[1]});
  assign p1y = $signed({py_r[1][pth_pkg::COORD_W-1], py_r[1]});

  always_comb begin
    // delayed heading of the previous point: forward difference for the
    // first point, central difference otherwise
    req_a.dx           = near ? (cx - p0x) : (cx - p1x);
    req_a.dy           = near ? (cy - p0y) : (cy - p1y);
    req_a.point_index  = seen_r - pth_pkg::INDEX_W'(1);
    req_a.last_heading = 1'b0;
    // heading of the last point: backward difference, zero on a lone point
    req_b.dx           = has_prev ? (cx - p0x) : '0;
    req_b.dy           = has_prev ? (cy - p0y) : '0;
    req_b.point_index  = seen_r;
    req_b.last_heading = 1'b1;
  end

  assign push_valid = pend_valid_r || (accept && (has_prev || in_data.end_of_path));
  assign push_req   = pend_valid_r ? pend_req_r : (has_prev ? req_a : req_b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r[0]      <= '0;
      px_r[1]      <= '0;
      py_r[0]      <= '0;
      py_r[1]      <= '0;
      seen_r       <= '0;
      pend_valid_r <= 1'b0;
    end else if (accept) begin
      // hold the last-point request when two leave on one item
      pend_valid_r <= has_prev && in_data.end_of_path;
      pend_req_r   <= req_b;
      if (in_data.end_of_path) begin
        px_r[0] <= '0;
        px_r[1] <= '0;
        py_r[0] <= '0;
        py_r[1] <= '0;
        seen_r  <= '0;
      end else begin
        px_r[1] <= px_r[0];
        py_r[1] <= py_r[0];
        px_r[0] <= in_data.x_coord;
        py_r[0] <= in_data.y_coord;
        if (seen_r != pth_pkg::INDEX_MAX) begin
          seen_r <= seen_r + pth_pkg::INDEX_W'(1);
        end
      end
    end else if (pend_valid_r && push_ready) begin
      pend_valid_r <= 1'b0;
    end
  end

endmodule

// ===== rtl/pth_queue.sv =====
// Short request queue between the front end and the CORDIC pipeline.
module pth_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  pth_pkg::req_t push_req,
  output logic          pop_valid,
  input  logic          pop,
  output pth_pkg::req_t pop_req
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  pth_pkg::req_t    slot_r [0:DEPTH-1];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [PTR_W:0]   cnt_r;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != (PTR_W+1)'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_req    = slot_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_r] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= wr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_r <= rd_r + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + (PTR_W+1)'(1);
        2'b01:   cnt_r <= cnt_r - (PTR_W+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== rtl/pth_cordic.sv =====
// Back end: pipelined vectoring CORDIC, rounding and output register.
module pth_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  output logic              req_pop,
  input  pth_pkg::req_t     req,
  output logic              out_valid,
  input  logic              out_ready,
  output pth_pkg::out_item_t out_data
);

  localparam int RW = pth_pkg::ROT_W;
  localparam int PW = pth_pkg::PHASE_W;
  localparam int IW = pth_pkg::INDEX_W;

  logic signed [RW-1:0] x_r    [0:CORDIC_STEPS];
  logic signed [RW-1:0] y_r    [0:CORDIC_STEPS];
  logic [PW-1:0]        z_r    [0:CORDIC_STEPS];
  logic [IW-1:0]        idx_r  [0:CORDIC_STEPS];
  logic                 last_r [0:CORDIC_STEPS];
  logic                 zero_r [0:CORDIC_STEPS];
  logic [CORDIC_STEPS:0] vld_r;

  logic                 out_valid_r;
  pth_pkg::out_item_t   out_data_r;

  logic                 adv;
  logic signed [RW-1:0] dxe, dye, x0, y0;
  logic [PW-1:0]        z0;
  logic [PW-1:0]        z_round;

  // the whole pipe moves when the output register can take a result
  assign adv     = !out_valid_r || out_ready;
  assign req_pop = adv && req_valid;

  assign dxe = RW'(req.dx);
  assign dye = RW'(req.dy);

  // fold the left half plane onto the right one
  always_comb begin
    x0 = dxe;
    y0 = dye;
    z0 = '0;
    if (dxe < 0) begin
      if (dye >= 0) begin
        x0 = dye;
        y0 = -dxe;
        z0 = pth_pkg::PHASE_QUARTER;
      end else begin
        x0 = -dye;
        y0 = dxe;
        z0 = pth_pkg::PHASE_3QUART;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[CORDIC_STEPS-1:0], req_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r[0]    <= x0;
      y_r[0]    <= y0;
      z_r[0]    <= z0;
      idx_r[0]  <= req.point_index;
      last_r[0] <= req.last_heading;
      zero_r[0] <= (req.dx == '0) && (req.dy == '0);
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [RW-1:0] xs, ys;
    logic [PW-1:0]        ang;

    assign xs  = x_r[i] >>> i;
    assign ys  = y_r[i] >>> i;
    assign ang = pth_pkg::atan_entry(5'(i));

    always_ff @(posedge clk) begin
      if (adv) begin
        if (y_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] + ys;
          y_r[i+1] <= y_r[i] - xs;
          z_r[i+1] <= z_r[i] + ang;
        end else begin
          x_r[i+1] <= x_r[i] - ys;
          y_r[i+1] <= y_r[i] + xs;
          z_r[i+1] <= z_r[i] - ang;
        end
        idx_r[i+1]  <= idx_r[i];
        last_r[i+1] <= last_r[i];
        zero_r[i+1] <= zero_r[i];
      end
    end
  end

  assign z_round = z_r[CORDIC_STEPS] + pth_pkg::PHASE_HALF_LSB;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.heading      <= zero_r[CORDIC_STEPS] ? '0 :
                                 $signed(z_round[PW-1 -: pth_pkg::ANGLE_W]);
      out_data_r.point_index  <= idx_r[CORDIC_STEPS];
      out_data_r.last_heading <= last_r[CORDIC_STEPS];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/path_tangent_heading.sv =====
// Tangent heading of each point of a streamed path.
//
// Input channel in_valid/in_ready/in_data carries one path point per request,
// with end_of_path set on the last point. The result channel out_valid/
// out_ready/out_data carries one heading per point, tagged with its index in
// the path and a flag on the last point's heading.
// An interior point's heading is known only when the next point arrives, so
// each heading follows the point after it; the last point of a path releases
// two headings, the one before it and its own.
// Throughput: one point per cycle while the queue has room; a last point that
// releases two headings holds in_ready low until its second heading request
// is pushed, as the request queue takes one heading request per cycle. The
// CORDIC pipeline is one stage per iteration. A heading passes through the
// queue, the queue read with pre-rotation, the iterations and the output
// register; a last point's own heading follows the one before it.
// Reset clears the point window and the index count; the next point starts a
// new path. When the receiver stalls, the output register holds its result,
// the pipeline freezes, the four-entry queue fills, and then in_ready drops.
module path_tangent_heading #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pth_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pth_pkg::out_item_t out_data
);

  logic          push_valid, push_ready;
  pth_pkg::req_t push_req;
  logic          pop_valid, pop;
  pth_pkg::req_t pop_req;

  pth_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_req   (push_req)
  );

  pth_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_req   (push_req),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_req    (pop_req)
  );

  pth_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (pop_valid),
    .req_pop   (pop),
    .req       (pop_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
